// File: design/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

  // Result kinds carried on the output tuser
  typedef enum logic [1:0] {
    EV_PAYLOAD    = 2'd0,
    EV_SYNC_MISS  = 2'd1,
    EV_LEN_REJECT = 2'd2,
    EV_EMPTY      = 2'd3
  } event_e;

  // Configuration register indexes
  localparam logic CfgSyncWord   = 1'b0;
  localparam logic CfgMaxPayload = 1'b1;

  // Configuration reset values
  localparam logic [31:0] SyncWordReset   = 32'hBEBA_BEEF;
  localparam logic [7:0]  MaxPayloadReset = 8'd255;

  // One result item
  typedef struct packed {
    event_e      event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic        last_byte;
    logic [15:0] frame_length;
  } result_t;

endpackage

// File: design/sld_out_reg.sv
`timescale 1ns / 1ps

// Output register with one skid entry so the producer keeps running
// while a finished result waits on the downstream side.
module sld_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sld_pkg::result_t push_data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output sld_pkg::result_t data_o
);
  import sld_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = out_valid_q & pop_ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // Slot steering
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// File: design/sync_length_deframer.sv
`timescale 1ns / 1ps

// Channel    | Dir | Signals                         | Content
// s_axis     | in  | tvalid tready tdata[7:0]        | rx_byte
// m_axis     | out | tvalid tready tdata tuser tlast | one result per event
// cfg        | in  | cfg_we_i cfg_idx_i cfg_wdata_i  | 0 sync_word, 1 max_payload
//
// One byte is taken per cycle while s_axis_tready is high; its result, if any, is
// registered. The frame state updates in the cycle of the transfer, so bytes follow
// back to back. A one-entry skid behind the output register holds one result while
// m_axis stalls, so s_axis_tready drops only while both output slots are full.
// Reset (rst_ni low, asynchronous) returns to the sync hunt and restores the registers.
module sync_length_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                      // [31:16] frame_length
  output logic [1:0]  m_axis_tuser,   // [1:0] event_res
  output logic        m_axis_tlast,   // last_byte
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import sld_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  position_q, position_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [7:0]  payload_length_q, payload_length_d;
  logic [31:0] sync_word_q;
  logic [7:0]  max_payload_q;

  logic        accept;
  logic        res_push;
  result_t     res;
  result_t     out_data;
  logic [7:0]  expect_byte;
  logic [15:0] len_full;
  logic [8:0]  idx_next;
  logic        is_last;

  assign accept = s_axis_tvalid & s_axis_tready;

  // Next expected sync byte, first byte in the top bits
  always_comb begin
    case (position_q[1:0])
      2'd0:    expect_byte = sync_word_q[31:24];
      2'd1:    expect_byte = sync_word_q[23:16];
      2'd2:    expect_byte = sync_word_q[15:8];
      default: expect_byte = sync_word_q[7:0];
    endcase
  end

  assign len_full = {length_high_q, s_axis_tdata};
  assign idx_next = {1'b0, position_q} + 9'd1;
  assign is_last  = idx_next >= {1'b0, payload_length_q};

  // Per-byte frame decode
  always_comb begin
    phase_d          = phase_q;
    position_d       = position_q;
    length_high_d    = length_high_q;
    payload_length_d = payload_length_q;
    res_push         = 1'b0;
    res.event_res    = EV_PAYLOAD;
    res.payload_byte = s_axis_tdata;
    res.byte_index   = 8'd0;
    res.last_byte    = 1'b0;
    res.frame_length = 16'd0;
    case (phase_q)
      PH_LEN: begin
        if (position_q == 8'd0) begin
          length_high_d = s_axis_tdata;
          position_d    = 8'd1;
        end else begin
          position_d = 8'd0;
          if (len_full > {8'd0, max_payload_q}) begin
            phase_d          = PH_HUNT;
            res_push         = 1'b1;
            res.event_res    = EV_LEN_REJECT;
            res.frame_length = len_full;
          end else if (len_full == 16'd0) begin
            phase_d       = PH_HUNT;
            res_push      = 1'b1;
            res.event_res = EV_EMPTY;
          end else begin
            payload_length_d = len_full[7:0];
            phase_d          = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_push         = 1'b1;
        res.event_res    = EV_PAYLOAD;
        res.byte_index   = position_q;
        res.last_byte    = is_last;
        res.frame_length = {8'd0, payload_length_q};
        if (is_last) begin
          phase_d    = PH_HUNT;
          position_d = 8'd0;
        end else begin
          position_d = idx_next[7:0];
        end
      end
      default: begin
        // Sync hunt; an unused phase code lands here too
        phase_d = PH_HUNT;
        if (s_axis_tdata != expect_byte) begin
          position_d    = 8'd0;
          res_push      = 1'b1;
          res.event_res = EV_SYNC_MISS;
        end else if (position_q[1:0] == 2'd3) begin
          phase_d    = PH_LEN;
          position_d = 8'd0;
        end else begin
          position_d = {6'd0, position_q[1:0] + 2'd1};
        end
      end
    endcase
  end

  // Frame state, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HUNT;
      position_q       <= 8'd0;
      length_high_q    <= 8'd0;
      payload_length_q <= 8'd0;
    end else if (accept) begin
      phase_q          <= phase_d;
      position_q       <= position_d;
      length_high_q    <= length_high_d;
      payload_length_q <= payload_length_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q   <= SyncWordReset;
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSyncWord:   sync_word_q   <= cfg_wdata_i;
        CfgMaxPayload: max_payload_q <= cfg_wdata_i[7:0];
        default:       ;
      endcase
    end
  end

  sld_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & res_push),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_data)
  );

  assign m_axis_tdata = {out_data.frame_length, out_data.byte_index, out_data.payload_byte};
  assign m_axis_tuser = out_data.event_res;
  assign m_axis_tlast = out_data.last_byte;

endmodule

// File: test/sync_length_deframer_test.sv
`timescale 1ns / 1ps

module sync_length_deframer_test;
  import sld_pkg::*;

  localparam int unsigned IdleLimit    = 2000;  // cycles without any transfer
  localparam int unsigned SettleCycles = 4;     // output register plus skid slot
  localparam int unsigned PhaseBytes   = 130;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2
  } frame_phase_e;

  // One row of the directed table; a typed row carries its own expected outcome
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    bit         has;
    result_t    r;
  } byte_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [7:0] payload_byte, [15:8] byte_index,
                                        // [31:16] frame_length
  logic [1:0]  m_axis_tuser;            // [1:0] event_res
  logic        m_axis_tlast;            // last_byte
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgSyncWord;
  logic [31:0] cfg_wdata_i = 32'h0;

  sync_length_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Deframer model: registers and frame state
  logic [31:0]  mdl_sync = SyncWordReset;
  logic [7:0]   mdl_max = MaxPayloadReset;
  frame_phase_e mdl_phase = PH_HUNT;
  logic [7:0]   mdl_pos = 8'h00;
  logic [7:0]   mdl_len_hi = 8'h00;
  logic [7:0]   mdl_pay_len = 8'h00;

  result_t     predicted_events[$];
  byte_row_t   table_rows[$];
  byte_row_t   pending_rows[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Stimulus side
  logic [31:0] cur_sync = SyncWordReset;
  logic [7:0]  cur_max = MaxPayloadReset;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  bit          no_gaps = 1'b0;

  // Advance the model by one byte; returns 1 when the byte produces a result
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [15:0] len;
    logic [8:0]  nxt;
    logic [7:0]  want;
    r = '0;
    case (mdl_phase)
      PH_LENGTH: begin
        if (mdl_pos == 8'd0) begin
          mdl_len_hi = b;
          mdl_pos = 8'd1;
          return 1'b0;
        end
        len = {mdl_len_hi, b};
        mdl_pos = 8'd0;
        if (len > {8'h00, mdl_max}) begin
          mdl_phase = PH_HUNT;
          r.event_res = EV_LEN_REJECT;
          r.payload_byte = b;
          r.frame_length = len;
          return 1'b1;
        end
        if (len == 16'd0) begin
          mdl_phase = PH_HUNT;
          r.event_res = EV_EMPTY;
          r.payload_byte = b;
          return 1'b1;
        end
        mdl_pay_len = len[7:0];
        mdl_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        nxt = {1'b0, mdl_pos} + 9'd1;
        r.event_res = EV_PAYLOAD;
        r.payload_byte = b;
        r.byte_index = mdl_pos;
        r.last_byte = (nxt >= {1'b0, mdl_pay_len});
        r.frame_length = {8'h00, mdl_pay_len};
        if (r.last_byte) begin
          mdl_phase = PH_HUNT;
          mdl_pos = 8'd0;
        end else begin
          mdl_pos = nxt[7:0];
        end
        return 1'b1;
      end
      default: begin
        // sync hunt; a mismatching byte is never retried as the first sync byte
        mdl_phase = PH_HUNT;
        want = mdl_sync[8 * (3 - mdl_pos[1:0]) +: 8];
        if (b != want) begin
          mdl_pos = 8'd0;
          r.event_res = EV_SYNC_MISS;
          r.payload_byte = b;
          return 1'b1;
        end
        if (mdl_pos[1:0] == 2'd3) begin
          mdl_phase = PH_LENGTH;
          mdl_pos = 8'd0;
        end else begin
          mdl_pos = {6'd0, mdl_pos[1:0]} + 8'd1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: ready follows a repeating random bit pattern, which is itself redrawn
  logic [15:0] ready_pat = 16'hFFFF;
  int unsigned ready_cyc = 0;

  always @(posedge clk_i) begin
    if (ready_cyc % 64 == 0) begin
      if ($urandom_range(0, 3) == 0) ready_pat = 16'hFFFF;
      else ready_pat = 16'($urandom) | 16'h0001;
    end
    m_axis_tready <= ready_pat[ready_cyc % 16];
    ready_cyc++;
  end

  // Monitor: model update on config writes and input transfers, check on output transfers
  bit        mon_hit;
  result_t   mon_res;
  result_t   mon_want;
  byte_row_t mon_row;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSyncWord) mdl_sync = cfg_wdata_i;
        else if (cfg_idx_i == CfgMaxPayload) mdl_max = cfg_wdata_i[7:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        mon_hit = deframe_byte(s_axis_tdata, mon_res);
        if (pending_rows.size() > 0) begin
          mon_row = pending_rows.pop_front();
          if (mon_row.typed) begin
            mon_hit = mon_row.has;
            mon_res = mon_row.r;
          end
        end
        if (mon_hit) predicted_events.push_back(mon_res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_events.size() == 0) begin
          $display("%0t: unexpected result: event %0d byte %h", $time, m_axis_tuser,
                   m_axis_tdata[7:0]);
          mismatches++;
        end else begin
          mon_want = predicted_events.pop_front();
          check_field("event_res", 16'(mon_want.event_res), 16'(m_axis_tuser));
          check_field("payload_byte", 16'(mon_want.payload_byte), 16'(m_axis_tdata[7:0]));
          check_field("byte_index", 16'(mon_want.byte_index), 16'(m_axis_tdata[15:8]));
          check_field("last_byte", 16'(mon_want.last_byte), 16'(m_axis_tlast));
          check_field("frame_length", mon_want.frame_length, m_axis_tdata[31:16]);
        end
      end
      // watchdog
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("[sync_length_deframer] ERROR");
        $finish;
      end
    end
  end

  task automatic add_row(input logic [7:0] rx, input bit typed, input bit has,
                         input result_t r);
    byte_row_t entry;
    entry.rx = rx;
    entry.typed = typed;
    entry.has = has;
    entry.r = r;
    table_rows.push_back(entry);
  endtask

  // Sender: one byte transfer, with bursts and random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  // Stop sending and wait until every predicted result has been seen; the first
  // edge lets the monitor record the last byte transfer before the queue is read
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (predicted_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Both registers, back to back; only called while the block is idle
  task automatic set_config(input logic [31:0] sync, input logic [7:0] maxp);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgSyncWord;
    cfg_wdata_i <= sync;
    @(posedge clk_i);
    cfg_idx_i <= CfgMaxPayload;
    cfg_wdata_i <= {24'h0, maxp};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_sync = sync;
    cur_max = maxp;
  endtask

  // One frame: sync word, big-endian length, payload; a broken frame is cut short
  task automatic send_frame(input bit broken);
    logic [7:0]  fb[$];
    logic [15:0] len;
    int unsigned pick;
    int unsigned lo;
    int unsigned cut;
    for (int k = 0; k < 4; k++) fb.push_back(cur_sync[8 * (3 - k) +: 8]);
    pick = $urandom_range(0, 99);
    if (pick < 10 || (pick >= 25 && cur_max == 8'd0)) begin
      len = 16'd0;
    end else if (pick < 25) begin
      lo = cur_max + 1;
      if ($urandom_range(0, 1) == 0) len = 16'(lo);
      else len = 16'($urandom_range(65535, lo));
    end else if ($urandom_range(0, 7) == 0) begin
      len = 16'($urandom_range(cur_max, 1));
    end else begin
      len = 16'($urandom_range((cur_max < 12) ? cur_max : 12, 1));
    end
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    if (len != 16'd0 && len <= {8'h00, cur_max}) begin
      repeat (len) fb.push_back(8'($urandom));
    end
    if (broken) begin
      cut = $urandom_range(fb.size() - 1, 1);
      while (fb.size() > cut) void'(fb.pop_back());
      if ($urandom_range(0, 1) == 0) fb.push_back(8'($urandom));
    end
    foreach (fb[k]) send_byte(fb[k]);
  endtask

  int unsigned phase_start;
  int unsigned frames;

  initial begin
    // Directed table, reset register values
    add_row(8'h00, 1, 1, result_t'{EV_SYNC_MISS, 8'h00, 8'h00, 1'b0, 16'h0000});
    add_row(8'hBE, 1, 0, '0);
    add_row(8'hBA, 1, 0, '0);
    add_row(8'hBE, 1, 0, '0);
    add_row(8'hEF, 1, 0, '0);
    add_row(8'h00, 1, 0, '0);
    // zero length: empty frame at once
    add_row(8'h00, 1, 1, result_t'{EV_EMPTY, 8'h00, 8'h00, 1'b0, 16'h0000});
    add_row(8'hBE, 0, 0, '0);
    add_row(8'hBA, 0, 0, '0);
    add_row(8'hBE, 0, 0, '0);
    add_row(8'hEF, 0, 0, '0);
    add_row(8'hFF, 0, 0, '0);
    // largest length field, rejected
    add_row(8'hFF, 1, 1, result_t'{EV_LEN_REJECT, 8'hFF, 8'h00, 1'b0, 16'hFFFF});
    add_row(8'hBE, 0, 0, '0);
    add_row(8'hBA, 0, 0, '0);
    add_row(8'hBE, 0, 0, '0);
    add_row(8'hEF, 0, 0, '0);
    add_row(8'h00, 0, 0, '0);
    add_row(8'h02, 0, 0, '0);
    add_row(8'hFF, 1, 1, result_t'{EV_PAYLOAD, 8'hFF, 8'h00, 1'b0, 16'h0002});
    add_row(8'h00, 1, 1, result_t'{EV_PAYLOAD, 8'h00, 8'h01, 1'b1, 16'h0002});
    // mismatching byte restarts the hunt and is not retried
    add_row(8'hBE, 0, 0, '0);
    add_row(8'hBE, 1, 1, result_t'{EV_SYNC_MISS, 8'hBE, 8'h00, 1'b0, 16'h0000});
    add_row(8'hBA, 1, 1, result_t'{EV_SYNC_MISS, 8'hBA, 8'h00, 1'b0, 16'h0000});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) begin
      pending_rows.push_back(table_rows[i]);
      send_byte(table_rows[i].rx);
    end
    settle();

    // Random frames under several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: set_config(32'h0000_0000, 8'd0);
        2: set_config(32'hFFFF_FFFF, 8'd255);
        3: set_config(32'hA5A5_A5A5, 8'($urandom_range(1, 255)));
        4: set_config($urandom, 8'($urandom_range(0, 40)));
        default: ;
      endcase
      no_gaps = (ph == 2);
      phase_start = bytes_sent;
      frames = 0;
      while (bytes_sent - phase_start < PhaseBytes) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
        send_frame($urandom_range(0, 99) < 15);
        frames++;
        if (frames == 2 || $urandom_range(0, 39) == 0) settle();
      end
      // leave the deframer mid-frame before the next register write
      send_frame(1'b1);
      settle();
    end

    if (mismatches == 0 && predicted_events.size() == 0) begin
      $display("[sync_length_deframer] OK");
    end else begin
      $display("[sync_length_deframer] ERROR");
    end
    $finish;
  end

endmodule
